>>> rtl/wbps_pkg.sv
package wbps_pkg;

   localparam int MaxPattern   = 16;
   localparam int OffsetBits   = 32;
   localparam int AddrBits     = 64;
   localparam int CsrDataBits  = 64;
   localparam int CsrIndexBits = 3;
   localparam int LenBits      = $clog2(MaxPattern + 1);
   localparam int PatIdxBits   = $clog2(MaxPattern);
   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueFillBits = $clog2(QueueDepth + 1);

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_CARE_MASK      = 3'd2,
      CSR_PATTERN_LENGTH = 3'd3,
      CSR_BASE_ADDRESS   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [8*MaxPattern-1:0] pattern;
      logic [MaxPattern-1:0]   care_mask;
      logic [LenBits-1:0]      length;
   } scan_cfg_type;

   typedef struct packed {
      logic                  found;
      logic [OffsetBits-1:0] offset;
   } scan_entry_type;

   typedef struct packed {
      logic                     full;
      logic                     empty;
      logic [QueueFillBits-1:0] fill;
   } queue_status_type;

endpackage

>>> rtl/wbps_if.sv
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        match_found;
   logic [63:0] match_address;

   modport source (output valid, output match_found, output match_address, input ready);
   modport sink   (input valid, input match_found, input match_address, output ready);
endinterface

>>> rtl/wbps_front.sv
module wbps_front (
   input  logic                         clock,
   input  logic                         reset,
   wbps_req_if.sink                     req_bus,
   input  wbps_pkg::scan_cfg_type       cfg,
   input  wbps_pkg::queue_status_type   q_status,
   output logic                         push,
   output wbps_pkg::scan_entry_type     entry
);
   import wbps_pkg::*;

   logic [7:0]            window_ff [MaxPattern];
   logic [7:0]            window_in [MaxPattern];
   logic [OffsetBits-1:0] count_ff;
   logic [OffsetBits-1:0] count_in;
   logic [OffsetBits-1:0] count_next;
   logic [OffsetBits-1:0] len_ext;
   logic [PatIdxBits-1:0] pat_idx [MaxPattern];
   logic [MaxPattern-1:0] mismatch;

   assign req_bus.ready = !q_status.full;
   assign push          = req_bus.valid && req_bus.ready;
   assign len_ext       = {{(OffsetBits-LenBits){1'b0}}, cfg.length};

   // hold the count at its maximum once saturated
   assign count_next = (&count_ff) ? count_ff : count_ff + 1'b1;
   assign count_in   = req_bus.last ? '0 : count_next;

   always_comb begin
      window_in[0] = req_bus.data_byte;
      for (int j = 1; j < MaxPattern; j++) begin
         window_in[j] = window_ff[j-1];
      end
   end

   // window entry j lines up with pattern byte length-1-j
   always_comb begin
      for (int j = 0; j < MaxPattern; j++) begin
         pat_idx[j]  = PatIdxBits'(cfg.length - LenBits'(1) - LenBits'(j));
         mismatch[j] = (LenBits'(j) < cfg.length) && cfg.care_mask[pat_idx[j]] &&
                       (window_in[j] != cfg.pattern[pat_idx[j]*8 +: 8]);
      end
   end

   assign entry.found  = (count_next >= len_ext) && (mismatch == '0);
   assign entry.offset = count_next - len_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int j = 0; j < MaxPattern; j++) begin
            window_ff[j] <= '0;
         end
      end else if (push) begin
         count_ff <= count_in;
         // drop the window after the final byte of an image
         for (int j = 0; j < MaxPattern; j++) begin
            window_ff[j] <= req_bus.last ? '0 : window_in[j];
         end
      end
   end

endmodule

>>> rtl/wbps_queue.sv
module wbps_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  wbps_pkg::scan_entry_type     push_entry,
   input  logic                         pop,
   output wbps_pkg::scan_entry_type     head,
   output wbps_pkg::queue_status_type   status
);
   import wbps_pkg::*;

   scan_entry_type           slot_ff [QueueDepth];
   logic [QueuePtrBits-1:0]  wr_ptr_ff;
   logic [QueuePtrBits-1:0]  rd_ptr_ff;
   logic [QueueFillBits-1:0] fill_ff;
   logic [QueueFillBits-1:0] fill_in;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.fill  = fill_ff;
   assign status.full  = (fill_ff == QueueFillBits'(QueueDepth));
   assign status.empty = (fill_ff == '0);

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

>>> rtl/wbps_back.sv
module wbps_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [wbps_pkg::AddrBits-1:0] base_address,
   input  wbps_pkg::scan_entry_type     head,
   input  wbps_pkg::queue_status_type   q_status,
   output logic                         pop,
   wbps_rsp_if.source                   rsp_bus
);
   import wbps_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   logic                found_ff;
   logic                found_in;
   logic [AddrBits-1:0] addr_ff;
   logic [AddrBits-1:0] addr_in;

   // advance when the output register is free or being drained
   assign pop      = !q_status.empty && (!valid_ff || rsp_bus.ready);
   assign found_in = head.found && (base_address != '0);
   assign addr_in  = found_in ?
                     base_address + {{(AddrBits-OffsetBits){1'b0}}, head.offset} : '0;

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         found_ff <= found_in;
         addr_ff  <= addr_in;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.match_found   = found_ff;
   assign rsp_bus.match_address = addr_ff;

endmodule

>>> rtl/wildcard_byte_pattern_scan_unit.sv
// Accepted beats are queued, then registered at the output. Throughput: one
// byte per cycle while the queue has room; the front compares the whole window
// at once; a four-entry queue feeds a registered address adder at the back.
// Reset (synchronous, active high): window and offset count clear, queue and
// output empty, registers return to zero and pattern length to one.
module wildcard_byte_pattern_scan_unit (
   input  logic                              clock,
   input  logic                              reset,
   wbps_req_if.sink                          req_bus,
   wbps_rsp_if.source                        rsp_bus,
   input  logic                              csr_write_enable,
   input  logic [wbps_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [wbps_pkg::CsrDataBits-1:0]  csr_write_data
);
   import wbps_pkg::*;

   logic [63:0]           pattern_low_ff;
   logic [63:0]           pattern_high_ff;
   logic [MaxPattern-1:0] care_mask_ff;
   logic [4:0]            pattern_length_ff;
   logic [AddrBits-1:0]   base_address_ff;
   logic [LenBits-1:0]    eff_length;

   scan_cfg_type     cfg;
   scan_entry_type   push_entry;
   scan_entry_type   head;
   queue_status_type q_status;
   logic             push;
   logic             pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '0;
         pattern_length_ff <= 5'd1;
         base_address_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_write_data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_write_data;
            CSR_CARE_MASK:      care_mask_ff      <= csr_write_data[MaxPattern-1:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_write_data[4:0];
            CSR_BASE_ADDRESS:   base_address_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // clamp length to 1..MaxPattern
   always_comb begin
      if (pattern_length_ff == '0) begin
         eff_length = LenBits'(1);
      end else if (pattern_length_ff > 5'(MaxPattern)) begin
         eff_length = LenBits'(MaxPattern);
      end else begin
         eff_length = LenBits'(pattern_length_ff);
      end
   end

   assign cfg.pattern   = {pattern_high_ff, pattern_low_ff};
   assign cfg.care_mask = care_mask_ff;
   assign cfg.length    = eff_length;

   wbps_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .cfg      (cfg),
      .q_status (q_status),
      .push     (push),
      .entry    (push_entry)
   );

   wbps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   wbps_back u_back (
      .clock        (clock),
      .reset        (reset),
      .base_address (base_address_ff),
      .head         (head),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_bus      (rsp_bus)
   );

   a_no_match_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.match_found |-> rsp_bus.match_address == '0)
      else $error("address nonzero on a beat without a match");

   a_zero_base_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.match_found |-> base_address_ff != '0)
      else $error("match reported with zero base address");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push && q_status.fill == QueueFillBits'(QueueDepth))
      else $error("queue written while full");

   a_push_fill: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> q_status.fill == $past(q_status.fill) + 1'b1)
      else $error("queue fill count lost a beat");

endmodule

>>> dv/wildcard_byte_pattern_scan_unit_tb.sv
`timescale 1ns / 1ps

module wildcard_byte_pattern_scan_unit_tb;
   import wbps_pkg::*;

   localparam int StuckLimit    = 2000;
   localparam int LongHold      = 80;
   localparam int PhaseCount    = 12;
   localparam int PhaseBytes    = 165;
   localparam int FirstUnusedCsr = int'(CSR_BASE_ADDRESS) + 1;
   localparam int LastCsr       = (1 << CsrIndexBits) - 1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } image_beat_type;

   typedef struct packed {
      logic          found;
      logic [63:0]   address;
   } match_report_type;

   logic clock = 1'b0;
   logic reset;
   logic                    csr_write_enable;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0]  csr_write_data;

   wbps_req_if req_bus ();
   wbps_rsp_if rsp_bus ();

   wildcard_byte_pattern_scan_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // register copies, window and offset count of the scanner
   logic [127:0]          cfg_pattern = '0;
   logic [15:0]           cfg_care    = '0;
   logic [LenBits-1:0]    cfg_length  = LenBits'(1);
   logic [63:0]           cfg_base    = '0;
   logic [7:0]            scan_window [MaxPattern];
   logic [OffsetBits-1:0] bytes_seen;

   image_beat_type   pending_bytes [$];
   match_report_type expected_matches [$];

   bit idle_on;
   int hold_requests;
   int hold_served;
   int error_count;
   int stuck_cycles;

   function automatic int effective_length();
      int len;
      len = cfg_length;
      if (len < 1) len = 1;
      if (len > MaxPattern) len = MaxPattern;
      return len;
   endfunction

   function automatic match_report_type predict_match(image_beat_type beat);
      match_report_type report;
      int               len;
      logic             hit;
      len = effective_length();
      report = '0;
      for (int k = MaxPattern - 1; k > 0; k--) scan_window[k] = scan_window[k-1];
      scan_window[0] = beat.data_byte;
      if (bytes_seen != {OffsetBits{1'b1}}) bytes_seen++;
      if (cfg_base != 0 && bytes_seen >= len) begin
         hit = 1'b1;
         for (int k = 0; k < len; k++) begin
            if (cfg_care[k] && scan_window[len-1-k] != cfg_pattern[8*k +: 8]) hit = 1'b0;
         end
         if (hit) begin
            report.found   = 1'b1;
            report.address = cfg_base + 64'(bytes_seen) - 64'(len);
         end
      end
      // a match never spans two images
      if (beat.last) begin
         bytes_seen = '0;
         foreach (scan_window[k]) scan_window[k] = '0;
      end
      return report;
   endfunction

   function automatic logic [7:0] pick_byte(bit narrow);
      logic [7:0] alphabet [4] = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
      if (narrow) return alphabet[2'($urandom_range(3))];
      return 8'($urandom);
   endfunction

   task automatic write_reg(logic [CsrIndexBits-1:0] idx, logic [63:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_PATTERN_LOW:    cfg_pattern[63:0]   = value;
         CSR_PATTERN_HIGH:   cfg_pattern[127:64] = value;
         CSR_CARE_MASK:      cfg_care            = value[15:0];
         CSR_PATTERN_LENGTH: cfg_length          = value[LenBits-1:0];
         CSR_BASE_ADDRESS:   cfg_base            = value;
         default: ;
      endcase
   endtask

   task automatic queue_beat(logic [7:0] data, logic last);
      image_beat_type beat;
      beat.data_byte = data;
      beat.last      = last;
      pending_bytes.insert(pending_bytes.size(), beat);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_bytes.size() != 0 || expected_matches.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // sender
   always @(posedge clock) begin : drive_bytes
      int  gap_left;
      bit  drive;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) void'(pending_bytes.pop_front());
         // hold the beat until it is taken
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (gap_left != 0) begin
               gap_left--;
               drive = 1'b0;
            end else if (idle_on && pending_bytes.size() != 0 && $urandom_range(9) == 0) begin
               gap_left = $urandom_range(13, 0);
               drive = 1'b0;
            end else begin
               drive = pending_bytes.size() != 0;
            end
            req_bus.valid <= drive;
            if (drive) begin
               req_bus.data_byte <= pending_bytes[0].data_byte;
               req_bus.last      <= pending_bytes[0].last;
            end
         end
      end
   end

   // receiver: predicts on each input beat, checks each result beat
   always @(posedge clock) begin : check_matches
      int               stall_left;
      int               hold_left;
      image_beat_type   beat;
      match_report_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         bytes_seen = '0;
         foreach (scan_window[k]) scan_window[k] = '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            beat.data_byte = req_bus.data_byte;
            beat.last      = req_bus.last;
            expected_matches.insert(expected_matches.size(), predict_match(beat));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_matches.size() == 0) begin
               $error("result beat with no byte pending: match_found %0d match_address %h",
                      rsp_bus.match_found, rsp_bus.match_address);
               error_count++;
            end else begin
               want = expected_matches.pop_front();
               if (rsp_bus.match_found !== want.found) begin
                  $error("match_found: expected %0d, got %0d", want.found, rsp_bus.match_found);
                  error_count++;
               end
               if (rsp_bus.match_address !== want.address) begin
                  $error("match_address: expected %h, got %h",
                         want.address, rsp_bus.match_address);
                  error_count++;
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LongHold;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(9) == 0) begin
            stall_left = $urandom_range(13, 0);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
         $display("[wildcard_byte_pattern_scan_unit] ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      image_beat_type img [$];
      logic [127:0] pat;
      int   eff_len;
      int   img_len;
      int   start;
      int   placed;
      bit   noisy;
      bit   narrow;

      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_index         = '0;
      csr_write_data    = '0;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last      = 1'b0;
      rsp_bus.ready     = 1'b0;
      idle_on           = 1'b1;
      hold_requests     = 0;
      hold_served       = 0;
      error_count       = 0;
      stuck_cycles      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // length zero acts as one; a single cared byte 0xFF
      write_reg(CSR_PATTERN_LOW, 64'hFF);
      write_reg(CSR_CARE_MASK, 64'h1);
      write_reg(CSR_PATTERN_LENGTH, 64'h0);
      write_reg(CSR_BASE_ADDRESS, 64'h1);
      for (int i = FirstUnusedCsr; i <= LastCsr; i++)
         write_reg(CsrIndexBits'(i), {$urandom, $urandom});
      @(negedge clock);
      queue_beat(8'h00, 1'b0);
      queue_beat(8'hFF, 1'b0);
      queue_beat(8'hFF, 1'b1);
      queue_beat(8'hFF, 1'b1);
      wait_drained();

      // AA ?? 55 with a base that wraps past the top of the address space
      write_reg(CSR_PATTERN_LOW, 64'h0055_00AA);
      write_reg(CSR_CARE_MASK, 64'b101);
      write_reg(CSR_PATTERN_LENGTH, 64'd3);
      write_reg(CSR_BASE_ADDRESS, '1);
      @(negedge clock);
      queue_beat(8'hAA, 1'b0);
      queue_beat(8'h00, 1'b0);
      queue_beat(8'h55, 1'b0);
      queue_beat(8'hAA, 1'b0);
      queue_beat(8'h12, 1'b0);
      queue_beat(8'h55, 1'b1);
      // pattern split across the image boundary
      queue_beat(8'hAA, 1'b0);
      queue_beat(8'h77, 1'b1);
      queue_beat(8'h55, 1'b0);
      queue_beat(8'h9C, 1'b1);
      wait_drained();

      // oversize length, all wildcards, reports off
      write_reg(CSR_PATTERN_HIGH, {$urandom, $urandom});
      write_reg(CSR_CARE_MASK, 64'h0);
      write_reg(CSR_PATTERN_LENGTH, 64'd31);
      write_reg(CSR_BASE_ADDRESS, 64'h0);
      @(negedge clock);
      for (int i = 0; i < 3; i++) queue_beat(8'($urandom), i == 2);
      wait_drained();

      for (int phase = 0; phase < PhaseCount; phase++) begin
         narrow = $urandom_range(2) == 0;
         for (int k = 0; k < 16; k++) pat[8*k +: 8] = pick_byte(narrow);
         write_reg(CSR_PATTERN_LOW, pat[63:0]);
         write_reg(CSR_PATTERN_HIGH, pat[127:64]);
         case (phase)
            0:       write_reg(CSR_CARE_MASK, 64'hFFFF);
            1:       write_reg(CSR_CARE_MASK, 64'h0);
            default: case ($urandom_range(3))
                        0: write_reg(CSR_CARE_MASK, 64'hFFFF);
                        1: write_reg(CSR_CARE_MASK, 64'($urandom_range(65535)));
                        default: write_reg(CSR_CARE_MASK,
                                           64'($urandom_range(65535) & $urandom_range(65535)));
                     endcase
         endcase
         case (phase)
            0:       write_reg(CSR_PATTERN_LENGTH, 64'd16);
            1:       write_reg(CSR_PATTERN_LENGTH, 64'd1);
            2:       write_reg(CSR_PATTERN_LENGTH, 64'd31);
            3:       write_reg(CSR_PATTERN_LENGTH, 64'd0);
            6:       write_reg(CSR_PATTERN_LENGTH, 64'd17);
            default: write_reg(CSR_PATTERN_LENGTH, 64'($urandom_range(20)));
         endcase
         case (phase)
            4:       write_reg(CSR_BASE_ADDRESS, 64'h0);
            5:       write_reg(CSR_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FF00 | $urandom_range(255));
            7:       write_reg(CSR_BASE_ADDRESS, 64'h1);
            default: write_reg(CSR_BASE_ADDRESS, {$urandom, $urandom});
         endcase
         if ($urandom_range(2) == 0)
            write_reg(CsrIndexBits'($urandom_range(LastCsr, FirstUnusedCsr)),
                      {$urandom, $urandom});
         eff_len = effective_length();

         @(negedge clock);
         idle_on = !(phase == 3 || phase >= PhaseCount - 2);
         if (phase == 2 || phase == 8) hold_requests++;

         placed = 0;
         while (placed < PhaseBytes) begin
            noisy   = $urandom_range(9) == 0;
            img_len = ($urandom_range(4) == 0) ? $urandom_range(4, 1) : $urandom_range(48, 5);
            img.delete();
            for (int i = 0; i < img_len; i++)
               img.insert(img.size(), {pick_byte(narrow && $urandom_range(1) == 0),
                                       noisy ? ($urandom_range(7) == 0) : (i == img_len - 1)});
            // plant whole occurrences with random bytes in the wildcard slots
            if (!noisy && img_len >= eff_len) begin
               repeat ($urandom_range(2)) begin
                  start = $urandom_range(img_len - eff_len, 0);
                  for (int k = 0; k < eff_len; k++)
                     if (cfg_care[k]) img[start+k].data_byte = cfg_pattern[8*k +: 8];
               end
            end
            foreach (img[i]) pending_bytes.insert(pending_bytes.size(), img[i]);
            placed += img_len;
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_matches.size() == 0) begin
         $display("[wildcard_byte_pattern_scan_unit] OK");
      end else begin
         $display("[wildcard_byte_pattern_scan_unit] ERROR");
      end
      $finish;
   end

endmodule
